### rtl/inverse_park_svpwm_q15_defines.svh
// ----------------------------------------------------------------------------
// inverse_park_svpwm_q15 assertion macros
// Clocked assertion wrappers; ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef INVERSE_PARK_SVPWM_Q15_DEFINES_SVH
`define INVERSE_PARK_SVPWM_Q15_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_CLK_ALWAYS(name, prop, msg)
`endif

`endif

### rtl/ivps_pkg.sv
// ----------------------------------------------------------------------------
// ivps_pkg
// Types, Q15 constants and sine table generator for the inverse Park / SVPWM
// pipeline.
// ----------------------------------------------------------------------------
package ivps_pkg;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic signed [15:0] Q15_SQRT3_BY_2 = 16'sd28378;
  localparam logic signed [15:0] Q15_INV_SQRT3  = 16'sd18919;
  localparam logic signed [21:0] Q15_HALF       = 22'sd16384;
  localparam logic signed [21:0] Q15_ONE        = 22'sd32768;

  localparam logic [15:0] PWM_MAX_RESET = 16'd1023;

  typedef struct packed {
    logic signed [15:0] uq;
    logic signed [15:0] ud;
    logic [14:0]        sin_mag;
    logic [14:0]        cos_mag;
    logic               sin_neg;
    logic               cos_neg;
  } ivps_trig_t;

  typedef struct packed {
    logic signed [18:0] pu;
    logic signed [18:0] pv;
    logic signed [18:0] pw;
  } ivps_phase_t;

  // round(32767*sin(m*pi/2/quarter)) by Q30 Taylor series, quarter = 2^(bits-2)
  function automatic logic [14:0] quarter_sine(input int unsigned m, input int tbl_bits);
    logic [63:0]        step;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        rnd;
    logic signed [63:0] sum;
    step = (PI_Q60 >> 1) >> (tbl_bits - 2);
    x    = (step * 64'(m)) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n < 14; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    rnd = (($unsigned(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    return rnd[14:0];
  endfunction

endpackage

### rtl/ivps_sincos.sv
// ----------------------------------------------------------------------------
// ivps_sincos
// Quarter-wave sine table lookup of sine and cosine, one registered stage.
// ----------------------------------------------------------------------------
module ivps_sincos
  import ivps_pkg::*;
#(
  parameter int TBL_BITS = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] voltage_q,
  input  logic signed [15:0] voltage_d,
  input  logic [15:0]        rotor_angle,
  output ivps_trig_t         trig
);

  localparam int QUARTER = 1 << (TBL_BITS - 2);
  localparam int HALF    = 1 << (TBL_BITS - 1);
  localparam int ADDR_W  = TBL_BITS - 1;

  logic [14:0]         qtab [QUARTER + 1];
  logic [TBL_BITS-1:0] sin_idx;
  logic [TBL_BITS-1:0] cos_idx;
  logic [ADDR_W-1:0]   sin_addr;
  logic [ADDR_W-1:0]   cos_addr;

  for (genvar i = 0; i <= QUARTER; i++) begin : g_tab
    assign qtab[i] = quarter_sine(i, TBL_BITS);
  end

  function automatic logic [ADDR_W-1:0] fold(input logic [TBL_BITS-1:0] k);
    logic [ADDR_W-1:0] m0;
    m0 = k[ADDR_W-1:0];
    if (m0 > ADDR_W'(QUARTER)) begin
      return ADDR_W'(HALF) - m0;
    end
    return m0;
  endfunction

  assign sin_idx  = rotor_angle[15 -: TBL_BITS];
  assign cos_idx  = sin_idx + TBL_BITS'(QUARTER);
  assign sin_addr = fold(sin_idx);
  assign cos_addr = fold(cos_idx);

  always_ff @(posedge clk) begin
    if (en) begin
      trig.uq      <= voltage_q;
      trig.ud      <= voltage_d;
      trig.sin_mag <= qtab[sin_addr];
      trig.cos_mag <= qtab[cos_addr];
      trig.sin_neg <= sin_idx[TBL_BITS-1];
      trig.cos_neg <= cos_idx[TBL_BITS-1];
    end
  end

endmodule

### rtl/ivps_xform.sv
// ----------------------------------------------------------------------------
// ivps_xform
// Inverse Park and inverse Clarke transforms, four register stages.
// ----------------------------------------------------------------------------
module ivps_xform
  import ivps_pkg::*;
(
  input  logic        clk,
  input  logic [3:0]  en,
  input  ivps_trig_t  trig,
  output ivps_phase_t phase
);

  logic signed [15:0] sin_v;
  logic signed [15:0] cos_v;
  logic signed [31:0] m_dc;
  logic signed [31:0] m_qs;
  logic signed [31:0] m_ds;
  logic signed [31:0] m_qc;
  logic signed [16:0] p_dc;
  logic signed [16:0] p_qs;
  logic signed [16:0] p_ds;
  logic signed [16:0] p_qc;

  logic signed [17:0] alpha;
  logic signed [17:0] beta;

  logic signed [18:0] neg_alpha;
  logic signed [33:0] m_beta;
  logic signed [17:0] pu;
  logic signed [17:0] half_na;
  logic signed [17:0] beta_sc;

  always_comb begin
    sin_v = trig.sin_neg ? -$signed({1'b0, trig.sin_mag}) : $signed({1'b0, trig.sin_mag});
    cos_v = trig.cos_neg ? -$signed({1'b0, trig.cos_mag}) : $signed({1'b0, trig.cos_mag});
    m_dc  = trig.ud * cos_v;
    m_qs  = trig.uq * sin_v;
    m_ds  = trig.ud * sin_v;
    m_qc  = trig.uq * cos_v;
  end

  // floor Q15 products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_dc <= m_dc[31:15];
      p_qs <= m_qs[31:15];
      p_ds <= m_ds[31:15];
      p_qc <= m_qc[31:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      alpha <= {p_dc[16], p_dc} - {p_qs[16], p_qs};
      beta  <= {p_ds[16], p_ds} + {p_qc[16], p_qc};
    end
  end

  // -1/2 * alpha is floor(-alpha / 2)
  always_comb begin
    neg_alpha = -{alpha[17], alpha};
    m_beta    = beta * Q15_SQRT3_BY_2;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pu      <= alpha;
      half_na <= neg_alpha[18:1];
      beta_sc <= m_beta[32:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      phase.pu <= {pu[17], pu};
      phase.pv <= {half_na[17], half_na} + {beta_sc[17], beta_sc};
      phase.pw <= {half_na[17], half_na} - {beta_sc[17], beta_sc};
    end
  end

endmodule

### rtl/ivps_svm.sv
// ----------------------------------------------------------------------------
// ivps_svm
// Min-max common mode removal, 1/sqrt3 scaling, clamp and PWM scaling,
// four register stages.
// ----------------------------------------------------------------------------
module ivps_svm
  import ivps_pkg::*;
(
  input  logic        clk,
  input  logic [3:0]  en,
  input  logic [15:0] pwm_max,
  input  ivps_phase_t phase,
  output logic [15:0] duty_u,
  output logic [15:0] duty_v,
  output logic [15:0] duty_w
);

  logic signed [18:0] vmax;
  logic signed [18:0] vmin;
  ivps_phase_t        ph;
  logic signed [19:0] mm_sum;

  logic signed [18:0] cm;
  logic signed [19:0] cen [3];

  logic signed [35:0] m_cen [3];
  logic signed [21:0] biased [3];
  logic [15:0]        d [3];

  logic [31:0]        raw [3];

  always_comb begin
    vmax = phase.pu;
    vmin = phase.pu;
    if (phase.pv > vmax) vmax = phase.pv;
    if (phase.pw > vmax) vmax = phase.pw;
    if (phase.pv < vmin) vmin = phase.pv;
    if (phase.pw < vmin) vmin = phase.pw;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ph     <= phase;
      mm_sum <= {vmax[18], vmax} + {vmin[18], vmin};
    end
  end

  assign cm = mm_sum[19:1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cen[0] <= {ph.pu[18], ph.pu} - {cm[18], cm};
      cen[1] <= {ph.pv[18], ph.pv} - {cm[18], cm};
      cen[2] <= {ph.pw[18], ph.pw} - {cm[18], cm};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_cen[i]  = cen[i] * Q15_INV_SQRT3;
      biased[i] = {m_cen[i][35], m_cen[i][35:15]} + Q15_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        if (biased[i] < 0) begin
          d[i] <= 16'd0;
        end else if (biased[i] > Q15_ONE) begin
          d[i] <= Q15_ONE[15:0];
        end else begin
          d[i] <= biased[i][15:0];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      raw[i] = d[i] * pwm_max;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      duty_u <= raw[0][30:15];
      duty_v <= raw[1][30:15];
      duty_w <= raw[2][30:15];
    end
  end

endmodule

### rtl/inverse_park_svpwm_q15.sv
// Latency: 9 register stages; output valid rises once an input transfer has
// passed through all of them, and the output transfers when out_ready is high.
// Throughput: one item per cycle; nine register stages each hold one item and
// advance on per-stage enables, so bubbles close up while the output stalls.
// Reset: clears all stage valid bits and loads the PWM full scale with 1023;
// datapath registers are not reset.
// ----------------------------------------------------------------------------
// inverse_park_svpwm_q15
// Q15 inverse Park, inverse Clarke and min-max SVPWM to three raw duties.
// ----------------------------------------------------------------------------
`include "inverse_park_svpwm_q15_defines.svh"

module inverse_park_svpwm_q15
  import ivps_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] voltage_q,
  input  logic signed [15:0] voltage_d,
  input  logic [15:0]        rotor_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        duty_phase_u,
  output logic [15:0]        duty_phase_v,
  output logic [15:0]        duty_phase_w,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam int STAGES = 9;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] en;
  logic [15:0]       pwm_full_scale;
  ivps_trig_t        trig;
  ivps_phase_t       phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_full_scale <= PWM_MAX_RESET;
    end else if (cfg_wr_en) begin
      pwm_full_scale <= cfg_wr_data;
    end
  end

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[STAGES-1];

  ivps_sincos #(
    .TBL_BITS(SINE_TABLE_BITS)
  ) u_sincos (
    .clk        (clk),
    .en         (en[0]),
    .voltage_q  (voltage_q),
    .voltage_d  (voltage_d),
    .rotor_angle(rotor_angle),
    .trig       (trig)
  );

  ivps_xform u_xform (
    .clk  (clk),
    .en   (en[4:1]),
    .trig (trig),
    .phase(phase)
  );

  ivps_svm u_svm (
    .clk    (clk),
    .en     (en[8:5]),
    .pwm_max(pwm_full_scale),
    .phase  (phase),
    .duty_u (duty_phase_u),
    .duty_v (duty_phase_v),
    .duty_w (duty_phase_w)
  );

  `ASSERT_CLK_ALWAYS(a_reset_empties, $past(rst) |-> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_full_when_blocked, !in_ready |-> (&valid), "input blocked with a free stage")
  `ASSERT_CLK(a_drain_last, (out_valid && out_ready && !valid[STAGES-2]) |=> !out_valid, "output repeated after transfer")

endmodule
